// ----- hw/rtl/rvc_pkg.sv -----
package rvc_pkg;

    // image limits used for coordinate clamping
    localparam int unsigned IMAGE_WIDTH  = 1280;
    localparam int unsigned IMAGE_HEIGHT = 960;

    localparam int unsigned SQRT_STEPS = 25;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned NUM_COEF   = 6;

    localparam logic [15:0] MAX_OUT = 16'hFFFF;
    localparam logic signed [31:0] ONE_Q24 = 32'sh0100_0000;

    // register indexes
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_COEF_1   = 3'd2;
    localparam logic [2:0] REG_COEF_2   = 3'd3;
    localparam logic [2:0] REG_COEF_3   = 3'd4;
    localparam logic [2:0] REG_COEF_4   = 3'd5;
    localparam logic [2:0] REG_COEF_5   = 3'd6;
    localparam logic [2:0] REG_COEF_6   = 3'd7;

    typedef struct packed {
        logic [15:0] pixel_value;
        logic [10:0] column;
        logic [9:0]  row;
    } t_in_item;

    typedef struct packed {
        logic [15:0] corrected_value;
        logic        clipped;
    } t_out_item;

    // square root chain: one root bit per cell
    typedef struct packed {
        logic        valid;
        logic [15:0] pix;
        logic [49:0] radicand;
        logic [24:0] root;
        logic [26:0] rem;
    } t_sqrt_bus;

    // polynomial chain: one addend per cell
    typedef struct packed {
        logic               valid;
        logic [15:0]        pix;
        logic [24:0]        radius;
        logic signed [31:0] acc;
    } t_horn_bus;

    typedef struct packed {
        logic               valid;
        logic [15:0]        pix;
        logic [24:0]        radius;
        logic signed [57:0] prod;
    } t_horn_mid;

    // divider chain: one quotient bit per cell
    typedef struct packed {
        logic        valid;
        logic        clip;
        logic [30:0] divisor;
        logic [31:0] rem;
        logic [15:0] quot;
    } t_div_bus;

endpackage

// ----- hw/rtl/rvc_sqrt_cell.sv -----
module rvc_sqrt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rvc_pkg::t_sqrt_bus i_bus,
    output rvc_pkg::t_sqrt_bus o_bus
);
    import rvc_pkg::*;

    t_sqrt_bus   r_bus;
    t_sqrt_bus   n_bus;
    logic [28:0] work;
    logic [28:0] trial;

    // bring down two radicand bits and try the next root bit
    always_comb begin
        work  = {i_bus.rem, i_bus.radicand[49:48]};
        trial = {2'b00, i_bus.root, 2'b01};
        n_bus          = i_bus;
        n_bus.radicand = {i_bus.radicand[47:0], 2'b00};
        if (work >= trial) begin
            n_bus.rem  = 27'(work - trial);
            n_bus.root = {i_bus.root[23:0], 1'b1};
        end else begin
            n_bus.rem  = work[26:0];
            n_bus.root = {i_bus.root[23:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/rvc_horner_cell.sv -----
module rvc_horner_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic signed [31:0] i_addend,
    input  rvc_pkg::t_horn_bus i_bus,
    output rvc_pkg::t_horn_bus o_bus
);
    import rvc_pkg::*;

    t_horn_mid          r_mid;
    t_horn_mid          n_mid;
    t_horn_bus          r_bus;
    t_horn_bus          n_bus;
    logic signed [33:0] scaled;
    logic signed [34:0] sum;

    // multiply accumulator by radius
    always_comb begin
        n_mid.valid  = i_bus.valid;
        n_mid.pix    = i_bus.pix;
        n_mid.radius = i_bus.radius;
        n_mid.prod   = i_bus.acc * $signed({1'b0, i_bus.radius});
    end

    // floor to q24, add the addend, saturate to 32 bits
    always_comb begin
        scaled       = 34'(r_mid.prod >>> 24);
        sum          = 35'(scaled) + 35'(i_addend);
        n_bus.valid  = r_mid.valid;
        n_bus.pix    = r_mid.pix;
        n_bus.radius = r_mid.radius;
        if (sum > 35'sh0_7FFF_FFFF) begin
            n_bus.acc = 32'sh7FFF_FFFF;
        end else if (sum < -35'sh0_8000_0000) begin
            n_bus.acc = 32'sh8000_0000;
        end else begin
            n_bus.acc = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= '0;
            r_bus <= '0;
        end else if (i_en) begin
            r_mid <= n_mid;
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/rvc_div_cell.sv -----
module rvc_div_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  rvc_pkg::t_div_bus i_bus,
    output rvc_pkg::t_div_bus o_bus
);
    import rvc_pkg::*;

    t_div_bus    r_bus;
    t_div_bus    n_bus;
    logic [32:0] shifted;

    // restoring step, one quotient bit
    always_comb begin
        shifted = {i_bus.rem, 1'b0};
        n_bus   = i_bus;
        if (shifted >= {2'b00, i_bus.divisor}) begin
            n_bus.rem  = 32'(shifted - {2'b00, i_bus.divisor});
            n_bus.quot = {i_bus.quot[14:0], 1'b1};
        end else begin
            n_bus.rem  = shifted[31:0];
            n_bus.quot = {i_bus.quot[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= '0;
        end else if (i_en) begin
            r_bus <= n_bus;
        end
    end

    assign o_bus = r_bus;

endmodule

// ----- hw/rtl/radial_vignetting_correction.sv -----
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined cell chains
// (25 square root cells, 6 two-stage polynomial cells, 16 divider cells)
// the whole pipeline holds while the output item waits under stall
// reset (synchronous, active low) empties the pipeline and loads
// center 10240/7680 and all coefficients zero
module radial_vignetting_correction (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  rvc_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output rvc_pkg::t_out_item o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rvc_pkg::*;

    localparam logic [10:0] MAX_COL = 11'(IMAGE_WIDTH - 1);
    localparam logic [9:0]  MAX_ROW = 10'(IMAGE_HEIGHT - 1);

    logic [14:0]        r_center_x;
    logic [14:0]        r_center_y;
    logic signed [31:0] r_coef [NUM_COEF];

    logic               en;
    logic               wr;
    logic [2:0]         reg_idx;

    // front stages
    logic               r_s0_valid;
    logic [15:0]        r_s0_pix;
    logic [10:0]        r_s0_col;
    logic [9:0]         r_s0_row;
    logic               r_s1_valid;
    logic [15:0]        r_s1_pix;
    logic [31:0]        r_s1_dx2;
    logic [31:0]        r_s1_dy2;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [33:0] dx2;
    logic signed [33:0] dy2;
    t_sqrt_bus          r_s2;
    t_sqrt_bus          n_s2;

    t_sqrt_bus          sqrt_bus [SQRT_STEPS + 1];
    t_horn_bus          horn_bus [NUM_COEF + 1];
    logic signed [31:0] addend   [NUM_COEF];
    t_div_bus           div_bus  [DIV_STEPS + 1];

    t_div_bus           r_prep;
    t_div_bus           n_prep;
    t_horn_bus          k_bus;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;

    // the chain moves unless a finished item is held at the output
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    // configuration port
    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= 15'd10240;
            r_center_y <= 15'd7680;
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (wr) begin
            unique case (reg_idx)
                REG_CENTER_X: r_center_x <= pwdata[14:0];
                REG_CENTER_Y: r_center_y <= pwdata[14:0];
                REG_COEF_1:   r_coef[0]  <= pwdata;
                REG_COEF_2:   r_coef[1]  <= pwdata;
                REG_COEF_3:   r_coef[2]  <= pwdata;
                REG_COEF_4:   r_coef[3]  <= pwdata;
                REG_COEF_5:   r_coef[4]  <= pwdata;
                REG_COEF_6:   r_coef[5]  <= pwdata;
                default:      ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_CENTER_X: prdata = {17'd0, r_center_x};
            REG_CENTER_Y: prdata = {17'd0, r_center_y};
            REG_COEF_1:   prdata = r_coef[0];
            REG_COEF_2:   prdata = r_coef[1];
            REG_COEF_3:   prdata = r_coef[2];
            REG_COEF_4:   prdata = r_coef[3];
            REG_COEF_5:   prdata = r_coef[4];
            REG_COEF_6:   prdata = r_coef[5];
            default:      prdata = '0;
        endcase
    end

    // input register with coordinate clamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_pix <= i_item.pixel_value;
            r_s0_col <= (i_item.column > MAX_COL) ? MAX_COL : i_item.column;
            r_s0_row <= (i_item.row > MAX_ROW) ? MAX_ROW : i_item.row;
        end
    end

    // offsets from the center and their squares
    always_comb begin
        dx  = $signed({2'b00, r_s0_col, 4'b0000}) - $signed({2'b00, r_center_x});
        dy  = $signed({3'b000, r_s0_row, 4'b0000}) - $signed({2'b00, r_center_y});
        dx2 = dx * dx;
        dy2 = dy * dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix <= r_s0_pix;
            r_s1_dx2 <= dx2[31:0];
            r_s1_dy2 <= dy2[31:0];
        end
    end

    // squared distance, scaled for the q24 radius
    always_comb begin
        n_s2.valid    = r_s1_valid;
        n_s2.pix      = r_s1_pix;
        n_s2.radicand = {r_s1_dx2 + r_s1_dy2, 18'd0};
        n_s2.root     = '0;
        n_s2.rem      = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= '0;
        end else if (en) begin
            r_s2 <= n_s2;
        end
    end

    // square root chain
    assign sqrt_bus[0] = r_s2;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        rvc_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (sqrt_bus[g]),
            .o_bus   (sqrt_bus[g + 1])
        );
    end

    // polynomial chain, highest coefficient seeds the accumulator
    always_comb begin
        horn_bus[0].valid  = sqrt_bus[SQRT_STEPS].valid;
        horn_bus[0].pix    = sqrt_bus[SQRT_STEPS].pix;
        horn_bus[0].radius = sqrt_bus[SQRT_STEPS].root;
        horn_bus[0].acc    = r_coef[NUM_COEF - 1];
    end

    for (genvar g = 0; g < NUM_COEF; g++) begin : g_horner
        if (g < NUM_COEF - 1) begin : g_coef
            assign addend[g] = r_coef[NUM_COEF - 2 - g];
        end else begin : g_one
            assign addend[g] = ONE_Q24;
        end

        rvc_horner_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_addend (addend[g]),
            .i_bus    (horn_bus[g]),
            .o_bus    (horn_bus[g + 1])
        );
    end

    assign k_bus = horn_bus[NUM_COEF];

    // divider setup: non-positive factor and overflow both clip
    always_comb begin
        n_prep.valid   = k_bus.valid;
        n_prep.divisor = k_bus.acc[30:0];
        n_prep.rem     = {8'd0, k_bus.pix, 8'd0};
        n_prep.quot    = '0;
        n_prep.clip    = k_bus.acc[31] || (k_bus.acc == '0)
                         || ({8'd0, k_bus.pix, 8'd0} >= {1'b0, k_bus.acc[30:0]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prep <= '0;
        end else if (en) begin
            r_prep <= n_prep;
        end
    end

    // divider chain
    assign div_bus[0] = r_prep;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        rvc_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bus   (div_bus[g]),
            .o_bus   (div_bus[g + 1])
        );
    end

    // output register
    always_comb begin
        n_out.clipped         = div_bus[DIV_STEPS].clip;
        n_out.corrected_value = div_bus[DIV_STEPS].clip ? MAX_OUT
                                                        : div_bus[DIV_STEPS].quot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_bus[DIV_STEPS].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef NO_ASSERTIONS
    // an unclipped item enters the divider with a remainder below the divisor
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prep.valid && !r_prep.clip) |-> (r_prep.rem < {1'b0, r_prep.divisor}))
        else $error("divider started with remainder not below divisor");

    // a held output item stays valid while the chain is frozen
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_out_valid)
        else $error("output item lost while pipeline held");

    // an accepted item enters the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && i_valid) |=> r_s0_valid)
        else $error("accepted item missing from first stage");

    // unclipped results have a remainder below the divisor at the end
    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_bus[DIV_STEPS].valid && !div_bus[DIV_STEPS].clip)
        |-> (div_bus[DIV_STEPS].rem < {1'b0, div_bus[DIV_STEPS].divisor}))
        else $error("divider ended with remainder not below divisor");
`endif

endmodule
